@@ rtl/efr_pkg.sv @@
// shared constants, types and the crc byte step of the escaped frame receiver
package efr_pkg;

  localparam int DATA_W           = 8;
  localparam int LEN_W            = 5;
  localparam int CRC_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int BUFFER_BYTES_DEF = 30;
  localparam int MIN_FRAME        = 3;

  localparam logic [DATA_W-1:0] ESCAPE_BYTE       = 8'd27;
  localparam logic [DATA_W-1:0] START_CODE_RST    = 8'd2;
  localparam logic [DATA_W-1:0] END_CODE_RST      = 8'd3;
  localparam logic [DATA_W-1:0] ESC_ESC_CODE_RST  = 8'd27;
  localparam logic [CRC_W-1:0]  CRC_INIT          = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY          = 16'h8408;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_ESC_CODE = 2'd2;

  // control from the sequencer to the crc unit
  typedef struct packed {
    logic init;
    logic step;
  } crc_ctrl_t;

  // reflected crc-ccitt over one byte, lsb first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, b};
    for (int k = 0; k < DATA_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/efr_in_if.sv @@
// received byte channel
interface efr_in_if;
  logic                         valid;
  logic                         ready;
  logic [efr_pkg::DATA_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/efr_out_if.sv @@
// payload byte result channel
interface efr_out_if;
  logic                         valid;
  logic                         ready;
  logic [efr_pkg::DATA_W-1:0]   payload_byte;
  logic                         last_byte;
  logic [efr_pkg::LEN_W-1:0]    payload_length;
  logic                         crc_ok;

  modport source (output valid, output payload_byte, output last_byte,
                  output payload_length, output crc_ok, input ready);
  modport sink   (input valid, input payload_byte, input last_byte,
                  input payload_length, input crc_ok, output ready);
endinterface

@@ rtl/efr_crc_unit.sv @@
// crc accumulator stepped one stored byte per command
module efr_crc_unit (
  input  logic                       clk,
  input  efr_pkg::crc_ctrl_t         ctrl,
  input  logic [efr_pkg::DATA_W-1:0] data_in,
  output logic                       crc_zero
);

  logic [efr_pkg::CRC_W-1:0] crc_r;

  // preset or fold in one byte
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      crc_r <= efr_pkg::CRC_INIT;
    end else if (ctrl.step) begin
      crc_r <= efr_pkg::crc_byte(crc_r, data_in);
    end
  end

  // residue of zero means the trailer matched
  assign crc_zero = (crc_r == '0);

endmodule

@@ rtl/escaped_frame_receiver_crc.sv @@
// escaped frame receiver: unstuffing, frame store, crc check and payload readout
// a plain or escape word is taken when ready; ready is low while a frame closes
// closing a frame of n stored bytes: per byte a store read (S_CRC_A) and a crc step
// (S_CRC_B), then per payload word S_EMIT_A, S_EMIT_B load, S_EMIT_B wait for ready
// rst_n (synchronous, active low) clears position, escape flag and sequencer, sets
// the codes; the frame store has no reset and is used only below the write position
module escaped_frame_receiver_crc #(
  parameter int BUFFER_BYTES = efr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  efr_in_if.sink                        in_chan,
  efr_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [efr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efr_pkg::DATA_W-1:0]    cfg_wdata
);

  localparam int POS_W = $clog2(BUFFER_BYTES);
  localparam int DW    = efr_pkg::DATA_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CRC_A  = 5'b00010,
    S_CRC_B  = 5'b00100,
    S_EMIT_A = 5'b01000,
    S_EMIT_B = 5'b10000
  } state_t;

  // emit run/wait substate, held in its own register beside the main state
  typedef enum logic [1:0] {
    E_RUN  = 2'b01,
    E_WAIT = 2'b10
  } emit_t;

  state_t              state_r, state_nxt;
  emit_t               emit_r, emit_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    idx_r, idx_nxt;
  logic                esc_r, esc_nxt;
  logic [DW-1:0]       start_code_r, end_code_r, esc_esc_code_r;

  logic [DW-1:0]       mem [BUFFER_BYTES];
  logic [DW-1:0]       rd_data_r;
  logic                wr_en;
  logic [DW-1:0]       wr_data;

  logic                out_vld_r;
  logic [DW-1:0]       out_byte_r;
  logic                out_last_r;
  logic [efr_pkg::LEN_W-1:0] out_len_r;
  logic                out_ok_r;
  logic                out_load;

  efr_pkg::crc_ctrl_t  crc_ctrl;
  logic                crc_zero;
  logic [POS_W-1:0]    payload;
  logic [DW-1:0]       c;

  assign payload = pos_r - POS_W'(2);
  assign c       = in_chan.rx_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r   <= efr_pkg::START_CODE_RST;
      end_code_r     <= efr_pkg::END_CODE_RST;
      esc_esc_code_r <= efr_pkg::ESC_ESC_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        efr_pkg::REG_START_CODE:   start_code_r   <= cfg_wdata;
        efr_pkg::REG_END_CODE:     end_code_r     <= cfg_wdata;
        efr_pkg::REG_ESC_ESC_CODE: esc_esc_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    rd_data_r <= mem[idx_r];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    esc_nxt   = esc_r;
    wr_en     = 1'b0;
    wr_data   = c;
    out_load  = 1'b0;
    crc_ctrl  = '0;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            if (c == start_code_r) begin
              pos_nxt = '0;
            end else if (c == end_code_r) begin
              if (pos_r >= POS_W'(efr_pkg::MIN_FRAME)) begin
                crc_ctrl.init = 1'b1;
                idx_nxt       = '0;
                state_nxt     = S_CRC_A;
              end
            end else if (c == esc_esc_code_r) begin
              wr_en   = 1'b1;
              wr_data = efr_pkg::ESCAPE_BYTE;
            end
          end else if (c == efr_pkg::ESCAPE_BYTE) begin
            esc_nxt = 1'b1;
          end else begin
            wr_en = 1'b1;
          end
          // advance and wrap on a stored word
          if (wr_en) begin
            pos_nxt = (pos_r == POS_W'(BUFFER_BYTES - 1)) ? '0 : pos_r + POS_W'(1);
          end
        end
      end
      S_CRC_A: begin
        state_nxt = S_CRC_B;
      end
      S_CRC_B: begin
        crc_ctrl.step = 1'b1;
        if (idx_r == pos_r - POS_W'(1)) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT_A;
          emit_nxt  = E_RUN;
        end else begin
          idx_nxt   = idx_r + POS_W'(1);
          state_nxt = S_CRC_A;
        end
      end
      S_EMIT_A: begin
        state_nxt = S_EMIT_B;
        emit_nxt  = E_RUN;
      end
      S_EMIT_B: begin
        case (emit_r)
          E_RUN: begin
            out_load = 1'b1;
            emit_nxt = E_WAIT;
          end
          E_WAIT: begin
            if (out_chan.ready) begin
              if (out_last_r) begin
                pos_nxt   = payload;
                state_nxt = S_IDLE;
              end else begin
                idx_nxt   = idx_r + POS_W'(1);
                state_nxt = S_EMIT_A;
              end
            end
          end
          default: emit_nxt = E_RUN;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_r  <= E_RUN;
      pos_r   <= '0;
      idx_r   <= '0;
      esc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
      pos_r   <= pos_nxt;
      idx_r   <= idx_nxt;
      esc_r   <= esc_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_vld_r && out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= rd_data_r;
      out_last_r <= (idx_r == payload - POS_W'(1));
      out_len_r  <= efr_pkg::LEN_W'(payload);
      out_ok_r   <= crc_zero;
    end
  end

  efr_crc_unit u_crc (
    .clk      (clk),
    .ctrl     (crc_ctrl),
    .data_in  (rd_data_r),
    .crc_zero (crc_zero)
  );

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_vld_r;
  assign out_chan.payload_byte   = out_byte_r;
  assign out_chan.last_byte      = out_last_r;
  assign out_chan.payload_length = out_len_r;
  assign out_chan.crc_ok         = out_ok_r;

endmodule
